/* src/m68k_exception_frame_builder_defines.svh */
// Assertion macros shared by the exception frame builder modules
`ifndef M68K_EXCEPTION_FRAME_BUILDER_DEFINES_SVH
`define M68K_EXCEPTION_FRAME_BUILDER_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define MEFB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mefb assertion failed");

// Next-cycle implication, disabled while in reset
`define MEFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mefb assertion failed");

`endif

/* src/mefb_pkg.sv */
// Types and constants of the exception frame builder
`default_nettype none

package mefb_pkg;

    localparam int unsigned SR_BIT_T1 = 15;
    localparam int unsigned SR_BIT_T0 = 14;
    localparam int unsigned SR_BIT_S  = 13;
    localparam int unsigned SR_BIT_M  = 12;

    localparam int unsigned FMT_LSB = 12;
    localparam int unsigned VEC_W   = 12;

    localparam logic [3:0] FMT_CODE_ADDR2 = 4'd2;
    localparam logic [3:0] FMT_CODE_ADDR3 = 4'd3;
    localparam logic [3:0] FMT_CODE_FAULT = 4'd4;

    localparam logic [31:0] HDR_BYTES       = 32'd8;
    localparam logic [31:0] EXTRA_ONE_BYTES = 32'd4;
    localparam logic [31:0] EXTRA_TWO_BYTES = 32'd8;
    localparam logic [31:0] OFS_PC          = 32'd2;
    localparam logic [31:0] OFS_FV          = 32'd6;
    localparam logic [31:0] OFS_EXTRA0      = 32'd8;
    localparam logic [31:0] OFS_EXTRA1      = 32'd12;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_FINAL = 1'b1;

    typedef enum logic [1:0] {
        FMT_NONE,
        FMT_ONE,
        FMT_TWO
    } t_fmt_class;

    typedef enum logic [2:0] {
        ST_START,
        ST_EXTRA0,
        ST_EXTRA1,
        ST_SR,
        ST_PC,
        ST_FV,
        ST_FINAL
    } t_step;

    typedef struct packed {
        logic [15:0] status_word;
        logic [15:0] format_vector;
        logic [31:0] extra_address;
        logic [31:0] fault_address;
        logic [31:0] program_counter;
        logic [31:0] active_stack_ptr;
        logic [31:0] interrupt_stack_ptr;
        logic [31:0] master_stack_ptr;
    } t_request;

    typedef struct packed {
        logic        item_kind;
        logic [31:0] write_address;
        logic [31:0] write_data;
        logic        write_long;
        logic [15:0] new_status;
        logic [31:0] new_stack_ptr;
        logic        update_master;
        logic        user_saved;
        logic [31:0] saved_user_stack_ptr;
        logic [31:0] vector_fetch_address;
        logic        last;
    } t_result;

    typedef struct packed {
        t_fmt_class  fmt_class;
        logic [31:0] hdr_base;
        logic [15:0] frame_sr;
        logic [15:0] new_sr;
        logic [15:0] format_vector;
        logic [31:0] extra_address;
        logic [31:0] fault_address;
        logic [31:0] program_counter;
        logic        user_saved;
        logic [31:0] saved_usp;
        logic [31:0] vec_addr;
    } t_frame_desc;

endpackage

`default_nettype wire

/* src/mefb_front.sv */
// Request classifier: picks the stack, sizes the frame, holds the vector base
`default_nettype none

module mefb_front import mefb_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire t_request    i_request,
    input  wire logic        i_cfg_valid,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_q_full,
    output t_frame_desc      o_desc,
    output logic             o_desc_push
);

    logic [31:0] r_vector_base;
    logic [31:0] n_vector_base;
    t_fmt_class  fmt_class;
    logic [3:0]  fmt;
    logic [31:0] base;
    logic [31:0] frame_bytes;
    logic [15:0] sr;

    always_comb begin
        n_vector_base = r_vector_base;
        if (i_cfg_valid) begin
            n_vector_base = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vector_base <= '0;
        end else begin
            r_vector_base <= n_vector_base;
        end
    end

    assign sr  = i_request.status_word;
    assign fmt = i_request.format_vector[FMT_LSB +: 4];

    always_comb begin
        case (fmt) inside
            FMT_CODE_ADDR2, FMT_CODE_ADDR3: begin
                fmt_class = FMT_ONE;
            end
            FMT_CODE_FAULT: begin
                fmt_class = FMT_TWO;
            end
            default: begin
                fmt_class = FMT_NONE;
            end
        endcase
    end

    always_comb begin
        case (fmt_class)
            FMT_ONE: begin
                frame_bytes = HDR_BYTES + EXTRA_ONE_BYTES;
            end
            FMT_TWO: begin
                frame_bytes = HDR_BYTES + EXTRA_TWO_BYTES;
            end
            default: begin
                frame_bytes = HDR_BYTES;
            end
        endcase
    end

    always_comb begin
        if (sr[SR_BIT_S]) begin
            base = i_request.active_stack_ptr;
        end else if (sr[SR_BIT_M]) begin
            base = i_request.master_stack_ptr;
        end else begin
            base = i_request.interrupt_stack_ptr;
        end
    end

    always_comb begin
        o_desc                 = '0;
        o_desc.fmt_class       = fmt_class;
        o_desc.hdr_base        = base - frame_bytes;
        o_desc.frame_sr        = (sr[1] ^ sr[0]) ? (sr ^ 16'h0003) : sr;
        o_desc.new_sr          = sr;
        o_desc.new_sr[SR_BIT_S]  = 1'b1;
        o_desc.new_sr[SR_BIT_T0] = 1'b0;
        o_desc.new_sr[SR_BIT_T1] = 1'b0;
        o_desc.format_vector   = i_request.format_vector;
        o_desc.extra_address   = i_request.extra_address;
        o_desc.fault_address   = i_request.fault_address;
        o_desc.program_counter = i_request.program_counter;
        o_desc.user_saved      = !sr[SR_BIT_S];
        o_desc.saved_usp       = sr[SR_BIT_S] ? 32'd0 : i_request.active_stack_ptr;
        o_desc.vec_addr        = r_vector_base
                               + {20'd0, i_request.format_vector[VEC_W-1:0]};
    end

    assign o_desc_push = i_push && !i_q_full;

endmodule

`default_nettype wire

/* src/mefb_queue.sv */
// Short descriptor queue between classifier and frame sequencer
`default_nettype none

`include "m68k_exception_frame_builder_defines.svh"

module mefb_queue import mefb_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire t_frame_desc i_desc,
    output logic             o_full,
    input  wire logic        i_pop,
    output logic             o_valid,
    output t_frame_desc      o_desc
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_frame_desc        r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_desc  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    `MEFB_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH))
    `MEFB_ASSERT_IMPL(a_pop_nonempty, i_clk, i_rst_n, i_pop, r_count != '0)
    `MEFB_ASSERT_IMPL(a_push_notfull, i_clk, i_rst_n, i_push, r_count != CNT_W'(DEPTH))

endmodule

`default_nettype wire

/* src/mefb_back.sv */
// Frame sequencer: one write or final item per cycle into the result register while it is free or being popped
`default_nettype none

`include "m68k_exception_frame_builder_defines.svh"

module mefb_back import mefb_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_desc_valid,
    input  wire t_frame_desc i_desc,
    output logic             o_desc_pop,
    output t_result          o_result,
    output logic             o_empty,
    input  wire logic        i_pop
);

    t_step   r_step;
    t_step   n_step;
    t_step   cur_step;
    t_result r_out;
    t_result n_out;
    logic    r_out_valid;
    logic    n_out_valid;
    logic    advance;
    logic    fire;
    logic    fire_final;

    assign advance    = !r_out_valid || i_pop;
    assign fire       = advance && i_desc_valid;
    assign fire_final = fire && (cur_step == ST_FINAL);

    always_comb begin
        cur_step = r_step;
        if (r_step == ST_START) begin
            cur_step = (i_desc.fmt_class == FMT_NONE) ? ST_SR : ST_EXTRA0;
        end
    end

    always_comb begin
        n_step = r_step;
        if (fire) begin
            case (cur_step)
                ST_EXTRA0: begin
                    n_step = (i_desc.fmt_class == FMT_TWO) ? ST_EXTRA1 : ST_SR;
                end
                ST_EXTRA1: begin
                    n_step = ST_SR;
                end
                ST_SR: begin
                    n_step = ST_PC;
                end
                ST_PC: begin
                    n_step = ST_FV;
                end
                ST_FV: begin
                    n_step = ST_FINAL;
                end
                default: begin
                    n_step = ST_START;
                end
            endcase
        end
    end

    always_comb begin
        n_out      = '0;
        o_desc_pop = 1'b0;
        case (cur_step)
            ST_EXTRA0: begin
                n_out.write_address = i_desc.hdr_base + OFS_EXTRA0;
                n_out.write_data    = (i_desc.fmt_class == FMT_TWO) ? i_desc.fault_address
                                                                    : i_desc.extra_address;
                n_out.write_long    = 1'b1;
            end
            ST_EXTRA1: begin
                n_out.write_address = i_desc.hdr_base + OFS_EXTRA1;
                n_out.write_data    = i_desc.extra_address;
                n_out.write_long    = 1'b1;
            end
            ST_SR: begin
                n_out.write_address = i_desc.hdr_base;
                n_out.write_data    = {16'd0, i_desc.frame_sr};
            end
            ST_PC: begin
                n_out.write_address = i_desc.hdr_base + OFS_PC;
                n_out.write_data    = i_desc.program_counter;
                n_out.write_long    = 1'b1;
            end
            ST_FV: begin
                n_out.write_address = i_desc.hdr_base + OFS_FV;
                n_out.write_data    = {16'd0, i_desc.format_vector};
            end
            ST_FINAL: begin
                n_out.new_status           = i_desc.new_sr;
                n_out.new_stack_ptr        = i_desc.hdr_base;
                n_out.update_master        = i_desc.new_sr[SR_BIT_M];
                n_out.user_saved           = i_desc.user_saved;
                n_out.saved_user_stack_ptr = i_desc.saved_usp;
                n_out.vector_fetch_address = i_desc.vec_addr;
                n_out.last                 = 1'b1;
                o_desc_pop                 = fire;
            end
            default: begin
                n_out = '0;
            end
        endcase
        n_out.item_kind = (cur_step == ST_FINAL) ? KIND_FINAL : KIND_WRITE;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (fire) begin
            n_out_valid = 1'b1;
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= ST_START;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_result = r_out;
    assign o_empty  = !r_out_valid;

    `MEFB_ASSERT_IMPL(a_mid_run_desc, i_clk, i_rst_n, r_step != ST_START, i_desc_valid)
    `MEFB_ASSERT_NEXT(a_final_restart, i_clk, i_rst_n, fire_final, r_step == ST_START)
    `MEFB_ASSERT_IMPL(a_pop_on_final, i_clk, i_rst_n, o_desc_pop, fire_final)

endmodule

`default_nettype wire

/* src/m68k_exception_frame_builder.sv */
// Top level of the exception frame builder
// Each request yields four to six result items: the extra longwords for
// formats 2, 3 and 4, the status word, program counter and format/vector
// writes, then one final item with the new status, new stack pointer and
// vector fetch address. The frame sequencer issues one result item per
// clock while its result register is empty or being popped; the
// classified-request queue holds up to QUEUE_DEPTH requests, the one being
// sequenced included, and a new request is taken every cycle while that
// queue has room. The vector base register is written through the cfg
// channel, which is always ready.
`default_nettype none

module m68k_exception_frame_builder import mefb_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire t_request    i_request,
    output logic             empty,
    input  wire logic        pop,
    output t_result          o_result,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_data
);

    t_frame_desc front_desc;
    t_frame_desc head_desc;
    logic        desc_push;
    logic        desc_pop;
    logic        head_valid;
    logic        q_full;

    assign o_cfg_ready = 1'b1;
    assign full        = q_full;

    mefb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_request   (i_request),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_desc      (front_desc),
        .o_desc_push (desc_push)
    );

    mefb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (desc_push),
        .i_desc  (front_desc),
        .o_full  (q_full),
        .i_pop   (desc_pop),
        .o_valid (head_valid),
        .o_desc  (head_desc)
    );

    mefb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc_valid (head_valid),
        .i_desc       (head_desc),
        .o_desc_pop   (desc_pop),
        .o_result     (o_result),
        .o_empty      (empty),
        .i_pop        (pop)
    );

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench for the m68k exception frame builder
`default_nettype none

module tb_top import mefb_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RX_HOLD_CYCLES = 80;
    localparam int SETTLE_CYCLES  = 20;
    localparam int MAX_REPORTS    = 40;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    t_request    i_request = '0;
    logic        empty;
    logic        pop = 1'b0;
    t_result     o_result;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data = '0;

    t_result     frame_q[$];
    logic [31:0] frame_vbase = '0;
    int          fail_count = 0;
    bit          quiet = 1'b0;
    bit          rx_hold = 1'b0;

    m68k_exception_frame_builder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_request   (i_request),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic void stack_write(input logic [31:0] addr, input logic [31:0] data,
                                        input logic is_long);
        t_result wr;
        wr = '0;
        wr.item_kind = KIND_WRITE;
        wr.write_address = addr;
        wr.write_data = is_long ? data : {16'h0, data[15:0]};
        wr.write_long = is_long;
        frame_q.push_back(wr);
    endfunction

    function automatic void build_frame(input t_request req);
        t_result     fin;
        logic [31:0] sp;
        logic [3:0]  fmt;
        logic [15:0] ssr;
        fin = '0;
        fmt = req.format_vector[15:12];
        sp = req.active_stack_ptr;
        if (!req.status_word[SR_BIT_S]) begin
            fin.user_saved = 1'b1;
            fin.saved_user_stack_ptr = sp;
            sp = req.status_word[SR_BIT_M] ? req.master_stack_ptr : req.interrupt_stack_ptr;
        end
        if (fmt == FMT_CODE_ADDR2 || fmt == FMT_CODE_ADDR3) begin
            sp = sp - EXTRA_ONE_BYTES;
            stack_write(sp, req.extra_address, 1'b1);
        end else if (fmt == FMT_CODE_FAULT) begin
            sp = sp - EXTRA_TWO_BYTES;
            stack_write(sp, req.fault_address, 1'b1);
            stack_write(sp + EXTRA_ONE_BYTES, req.extra_address, 1'b1);
        end
        ssr = req.status_word;
        if (ssr[1] ^ ssr[0]) begin
            ssr[1:0] = ~ssr[1:0];
        end
        sp = sp - HDR_BYTES;
        stack_write(sp, {16'h0, ssr}, 1'b0);
        stack_write(sp + OFS_PC, req.program_counter, 1'b1);
        stack_write(sp + OFS_FV, {16'h0, req.format_vector}, 1'b0);
        fin.item_kind = KIND_FINAL;
        fin.new_status = req.status_word;
        fin.new_status[SR_BIT_S] = 1'b1;
        fin.new_status[SR_BIT_T0] = 1'b0;
        fin.new_status[SR_BIT_T1] = 1'b0;
        fin.new_stack_ptr = sp;
        fin.update_master = req.status_word[SR_BIT_M];
        fin.vector_fetch_address = frame_vbase + {20'h0, req.format_vector[11:0]};
        fin.last = 1'b1;
        frame_q.push_back(fin);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            if (fail_count < MAX_REPORTS) begin
                $display("%0t: %s expected %h, got %h", $realtime, name, want, got);
            end
            fail_count++;
        end
    endfunction

    task automatic check_result(input t_result got);
        t_result want;
        if (frame_q.size() == 0) begin
            $display("%0t: result item expected none, got %h", $realtime, got);
            fail_count++;
        end else begin
            want = frame_q.pop_front();
            check_field("item_kind", 32'(want.item_kind), 32'(got.item_kind));
            check_field("write_address", want.write_address, got.write_address);
            check_field("write_data", want.write_data, got.write_data);
            check_field("write_long", 32'(want.write_long), 32'(got.write_long));
            check_field("new_status", 32'(want.new_status), 32'(got.new_status));
            check_field("new_stack_ptr", want.new_stack_ptr, got.new_stack_ptr);
            check_field("update_master", 32'(want.update_master), 32'(got.update_master));
            check_field("user_saved", 32'(want.user_saved), 32'(got.user_saved));
            check_field("saved_user_stack_ptr", want.saved_user_stack_ptr,
                        got.saved_user_stack_ptr);
            check_field("vector_fetch_address", want.vector_fetch_address,
                        got.vector_fetch_address);
            check_field("last", 32'(want.last), 32'(got.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                frame_vbase = i_cfg_data;
            end
            if (push && !full) begin
                build_frame(i_request);
            end
            if (pop && !empty) begin
                check_result(o_result);
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold) begin
                pop <= 1'b0;
                repeat (RX_HOLD_CYCLES - 1) @(posedge i_clk);
                rx_hold = 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 14) - 1) @(posedge i_clk);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    function automatic logic [31:0] pick_addr();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_request make_request(
        input logic [15:0] sr, input logic [15:0] fv, input logic [31:0] extra,
        input logic [31:0] fault, input logic [31:0] pc, input logic [31:0] a7,
        input logic [31:0] isp, input logic [31:0] msp);
        t_request req;
        req.status_word = sr;
        req.format_vector = fv;
        req.extra_address = extra;
        req.fault_address = fault;
        req.program_counter = pc;
        req.active_stack_ptr = a7;
        req.interrupt_stack_ptr = isp;
        req.master_stack_ptr = msp;
        return req;
    endfunction

    function automatic t_request random_request(input logic [3:0] fmt);
        logic [11:0] vec;
        logic [15:0] sr;
        vec = 12'($urandom_range(0, 4095));
        sr = 16'($urandom_range(0, 65535));
        return make_request(sr, {fmt, vec}, pick_addr(), pick_addr(), pick_addr(),
                            pick_addr(), pick_addr(), pick_addr());
    endfunction

    function automatic logic [3:0] random_format();
        case ($urandom_range(0, 7))
            0: return FMT_CODE_ADDR2;
            1: return FMT_CODE_ADDR3;
            2, 3: return FMT_CODE_FAULT;
            default: return 4'($urandom_range(0, 15));
        endcase
    endfunction

    task automatic send_request(input t_request req);
        push <= 1'b1;
        i_request <= req;
        do @(posedge i_clk); while (full);
    endtask

    task automatic sender_gap();
        if (!quiet && $urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        push <= 1'b0;
        do @(posedge i_clk); while (frame_q.size() != 0);
    endtask

    task automatic write_vector_base(input logic [31:0] base);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= base;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_special_frames();
        send_request(make_request(16'h2000, 16'h0000, '0, '0, '0, '0, '0, '0));
        send_request(make_request(16'hFFFF, 16'hFFFF, '1, '1, '1, '1, '1, '1));
        sender_gap();
        send_request(make_request(16'h0001, 16'h2004, 32'h1234_5678, 32'h0BAD_F00D,
                                  32'h0000_4000, 32'h0001_0000, 32'h0002_0000,
                                  32'h0003_0000));
        send_request(make_request(16'h1002, 16'h3FFC, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
                                  32'h00FF_FF00, 32'h7FFF_FFFC, 32'h8000_0000,
                                  32'h0000_1000));
        sender_gap();
        send_request(make_request(16'h2001, 16'h4010, 32'hDEAD_BEEF, 32'hCAFE_0001,
                                  32'h1000_0002, 32'h0000_0100, 32'h0, 32'h0));
        send_request(make_request(16'h0000, 16'h4080, 32'h1111_2222, 32'h3333_4444,
                                  32'h5555_6666, 32'h7777_8888, 32'h0000_0004,
                                  32'h9999_AAAA));
        send_request(make_request(16'hD003, 16'h4FFF, 32'hFFFF_0000, 32'h0000_FFFF,
                                  32'hFFFF_FFFE, 32'h0000_0010, 32'h0000_0020, 32'h0));
        sender_gap();
        send_request(make_request(16'h6002, 16'h1008, 32'h0, 32'h0, 32'h0040_0000,
                                  32'h0000_0008, '1, '1));
        send_request(make_request(16'h8000, 16'h9FFC, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
                                  32'h0000_0002, 32'h0000_0006, 32'h0000_000C,
                                  32'h0000_0014));
        drain();
    endtask

    task automatic test_format_sweep();
        int f;
        write_vector_base(32'hFFFF_FFFF);
        for (f = 0; f < 16; f++) begin
            send_request(random_request(f[3:0]));
            sender_gap();
        end
        drain();
    endtask

    task automatic test_random_traffic(input logic [31:0] base, input int count);
        int n;
        write_vector_base(base);
        for (n = 0; n < count; n++) begin
            send_request(random_request(random_format()));
            sender_gap();
        end
        drain();
    endtask

    task automatic test_backpressure();
        int n;
        write_vector_base(32'h0000_0000);
        rx_hold = 1'b1;
        for (n = 0; n < 16; n++) begin
            send_request(random_request(random_format()));
        end
        drain();
        for (n = 0; n < 6; n++) begin
            send_request(random_request(FMT_CODE_FAULT));
            sender_gap();
        end
        drain();
    endtask

    task automatic test_streaming(input int count);
        int n;
        quiet = 1'b1;
        write_vector_base($urandom);
        for (n = 0; n < count; n++) begin
            send_request(random_request(random_format()));
        end
        drain();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_special_frames();
        test_format_sweep();
        test_random_traffic($urandom, 75);
        test_backpressure();
        test_random_traffic(32'h8000_0000, 70);
        test_streaming(30);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && frame_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* m68k_exception_frame_builder.f */
+incdir+src
src/mefb_pkg.sv
src/mefb_front.sv
src/mefb_queue.sv
src/mefb_back.sv
src/m68k_exception_frame_builder.sv
dv/tb_top.sv
